FILE: src/idt_pkg.sv
// Shared types, codes and constants for the image download tracker.
// No dependencies; compiled first.
`default_nettype none

package idt_pkg;

  localparam int unsigned IDT_MAX_PACKETS  = 192;
  localparam int unsigned IDT_IMAGE_OFFSET = 10;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_PACKET   = 2'd1,
    OP_READBACK = 2'd2,
    OP_CONFIRM  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_RANGE      = 4'd1,
    ST_DUP        = 4'd2,
    ST_TAG        = 4'd3,
    ST_LEN        = 4'd4,
    ST_CTAG       = 4'd5,
    ST_UNCONF     = 4'd6,
    ST_INCOMPLETE = 4'd7,
    ST_CRCBAD     = 4'd8
  } status_t;

  localparam logic [1:0] CFG_TOTAL_PACKETS = 2'd0;
  localparam logic [1:0] CFG_PACKET_BYTES  = 2'd1;
  localparam logic [1:0] CFG_EXPECTED_CRC  = 2'd2;

  // Command to the received map and its answer.
  typedef struct packed {
    logic       clr;
    logic       set;
    logic [7:0] idx;
  } map_cmd_t;

  typedef struct packed {
    logic hit;
    logic all_after;
  } map_rsp_t;

  // Reflected CRC-CCITT, one byte per call.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ (d << 4);
    return {d, crc[15:8]} ^ {8'h00, (d >> 4)} ^ ({8'h00, d} << 3);
  endfunction

endpackage

`default_nettype wire

FILE: src/idt_if.sv
// Valid/ready channel interfaces for the tracker's command and result streams.
// Depends on nothing; follows idt_pkg.
`default_nettype none

interface idt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  packet_index;
  logic [15:0] image_tag;
  logic [7:0]  payload_length;
  logic [7:0]  data_byte;
  logic        restart_crc;

  modport source (output valid, op, packet_index, image_tag, payload_length, data_byte,
                  restart_crc, input ready);
  modport sink (input valid, op, packet_index, image_tag, payload_length, data_byte,
                restart_crc, output ready);
endinterface

interface idt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] flash_address;
  logic [15:0] image_size;
  logic [7:0]  packets_received;
  logic        all_received;
  logic [15:0] running_crc;
  logic        crc_match;

  modport source (output valid, status, flash_address, image_size, packets_received,
                  all_received, running_crc, crc_match, input ready);
  modport sink (input valid, status, flash_address, image_size, packets_received,
                all_received, running_crc, crc_match, output ready);
endinterface

`default_nettype wire

FILE: src/image_download_tracker_top.sv
// Image download tracker: one result per command, registered on the edge of the transfer.
// Latency: the result is valid in the cycle after the input transfer.
// Throughput: one command per cycle; the output register frees as its result is taken.
// Every command is resolved in one pass: map lookup, byte CRC and 8x8 address product.
// Reset (synchronous, rst_n low): map, count, config, valid cleared; CRC set to 0xFFFF.
// Depends on idt_pkg, idt_if and idt_map.
`default_nettype none

module image_download_tracker_top
  import idt_pkg::*;
#(
  parameter int unsigned MAX_PACKETS  = IDT_MAX_PACKETS,
  parameter int unsigned IMAGE_OFFSET = IDT_IMAGE_OFFSET
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  idt_in_if.sink           in_ch,
  idt_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [7:0]  MAX_B  = 8'(MAX_PACKETS);
  localparam logic [15:0] OFFSET = 16'(IMAGE_OFFSET);

  logic [7:0]  total_r;
  logic [7:0]  pbytes_r;
  logic [15:0] exp_crc_r;
  logic [7:0]  count_r;
  logic [7:0]  count_nxt;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_seed;

  logic        out_valid_r;
  status_t     status_r;
  status_t     status_nxt;
  logic [15:0] addr_r;
  logic [15:0] addr_nxt;
  logic [15:0] size_r;
  logic [7:0]  count_out_r;
  logic        all_r;
  logic [15:0] crc_out_r;
  logic        match_r;

  logic        accept;
  logic        total_we;
  op_t         op;
  logic        in_range;
  logic        pkt_ok;
  logic [15:0] size_c;
  logic [15:0] prod;
  map_cmd_t    map_cmd;
  map_rsp_t    map_rsp;

  assign op       = op_t'(in_ch.op);
  assign in_ch.ready = out_ch.ready || !out_valid_r;
  assign accept   = in_ch.valid && in_ch.ready;
  assign total_we = cfg_we && (cfg_index == CFG_TOTAL_PACKETS) && (cfg_wdata[7:0] <= MAX_B);

  assign in_range = (in_ch.packet_index < total_r) && (in_ch.packet_index < MAX_B);
  assign prod     = 16'(in_ch.packet_index) * 16'(pbytes_r);
  assign size_c   = 16'(total_r) * 16'(pbytes_r);
  assign crc_seed = in_ch.restart_crc ? CRC_INIT : crc_r;

  always_comb begin
    status_nxt = ST_OK;
    pkt_ok     = 1'b0;
    unique case (op)
      OP_CLEAR, OP_READBACK: status_nxt = ST_OK;
      OP_PACKET: begin
        if (!in_range)                              status_nxt = ST_RANGE;
        else if (map_rsp.hit)                       status_nxt = ST_DUP;
        else if (in_ch.image_tag != exp_crc_r)      status_nxt = ST_TAG;
        else if (in_ch.payload_length != pbytes_r)  status_nxt = ST_LEN;
        else                                        pkt_ok     = 1'b1;
      end
      OP_CONFIRM: begin
        if (in_ch.image_tag != exp_crc_r)             status_nxt = ST_CTAG;
        else if (pbytes_r == '0 || total_r == '0)     status_nxt = ST_UNCONF;
        else if (!map_rsp.all_after)                  status_nxt = ST_INCOMPLETE;
        else if (crc_r != exp_crc_r)                  status_nxt = ST_CRCBAD;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign map_cmd.clr = accept && (op == OP_CLEAR);
  assign map_cmd.set = accept && pkt_ok;
  assign map_cmd.idx = in_ch.packet_index;

  assign count_nxt = map_cmd.clr ? '0 : (map_cmd.set ? count_r + 8'd1 : count_r);
  assign crc_nxt   = (op == OP_READBACK) ? crc_byte(crc_seed, in_ch.data_byte) : crc_r;
  assign addr_nxt  = pkt_ok ? prod + OFFSET : '0;

  idt_map #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .total_we  (total_we),
    .total_val (cfg_wdata[7:0]),
    .cmd       (map_cmd),
    .rsp       (map_rsp)
  );

  // configuration and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      pbytes_r  <= '0;
      exp_crc_r <= '0;
      count_r   <= '0;
      crc_r     <= CRC_INIT;
    end else begin
      if (total_we) total_r <= cfg_wdata[7:0];
      if (cfg_we && cfg_index == CFG_PACKET_BYTES) pbytes_r <= cfg_wdata[7:0];
      if (cfg_we && cfg_index == CFG_EXPECTED_CRC) exp_crc_r <= cfg_wdata;
      if (accept) begin
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  // result register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      addr_r      <= addr_nxt;
      size_r      <= size_c;
      count_out_r <= count_nxt;
      all_r       <= map_rsp.all_after;
      crc_out_r   <= crc_nxt;
      match_r     <= map_rsp.all_after && (crc_nxt == exp_crc_r);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.flash_address    = addr_r;
  assign out_ch.image_size       = size_r;
  assign out_ch.packets_received = count_out_r;
  assign out_ch.all_received     = all_r;
  assign out_ch.running_crc      = crc_out_r;
  assign out_ch.crc_match        = match_r;

endmodule

`default_nettype wire

FILE: src/idt_map.sv
// Received-packet bitmap with its expected-packet mask and completeness test.
// Depends on idt_pkg.
`default_nettype none

module idt_map
  import idt_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = IDT_MAX_PACKETS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       total_we,
  input  wire logic [7:0] total_val,
  input  wire map_cmd_t   cmd,
  output map_rsp_t        rsp
);

  localparam int unsigned IDX_W = $clog2(MAX_PACKETS);

  logic [MAX_PACKETS-1:0] map_r;
  logic [MAX_PACKETS-1:0] map_nxt;
  logic [MAX_PACKETS-1:0] mask_r;
  logic [MAX_PACKETS-1:0] set_vec;
  logic [IDX_W-1:0]       idx_w;

  assign idx_w   = cmd.idx[IDX_W-1:0];
  assign set_vec = cmd.set ? (MAX_PACKETS'(1) << idx_w) : '0;
  assign map_nxt = cmd.clr ? '0 : (map_r | set_vec);

  // hit is only consulted once the index is known to be in range
  assign rsp.hit       = map_r[idx_w];
  assign rsp.all_after = &(map_nxt | ~mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r  <= '0;
      mask_r <= '0;
    end else begin
      map_r <= map_nxt;
      if (total_we) begin
        for (int i = 0; i < MAX_PACKETS; i++) begin
          mask_r[i] <= (9'(i) < {1'b0, total_val});
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/idt_checker.sv
// Port-level checks for the image download tracker, bound to its top level.
// Depends on idt_pkg and image_download_tracker_top.
`default_nettype none

module idt_checker
  import idt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_op,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_status,
  input wire logic [15:0] out_flash_address,
  input wire logic [15:0] out_running_crc,
  input wire logic        out_all_received,
  input wire logic        out_crc_match
);

  // result register empties on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_flash_address) && $stable(out_running_crc))
    else $error("stalled result changed");

  // a readback transfer always yields an ok result in the next cycle
  a_readback_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_READBACK |=> out_valid && out_status == ST_OK)
    else $error("readback result missing or not ok");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_flash_address == '0)
    else $error("flash address on a refused command");

  a_match_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crc_match |-> out_all_received)
    else $error("crc match without a complete image");

endmodule

bind image_download_tracker_top idt_checker u_idt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_op             (in_ch.op),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_flash_address (out_ch.flash_address),
  .out_running_crc   (out_ch.running_crc),
  .out_all_received  (out_ch.all_received),
  .out_crc_match     (out_ch.crc_match)
);

`default_nettype wire
